@@ rtl/fgp_pkg.sv @@
// Shared types, stage map and constants for the follow goal point pipeline.
`default_nettype none
package fgp_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ISQRT_STAGES  = 32;
	localparam int DIV_STAGES    = 32;

	// Pipeline stage numbers (register index at which a value is held)
	localparam int ST_SUM  = 3;
	localparam int ST_ROOT = ST_SUM + ISQRT_STAGES;
	localparam int ST_DIFF = ST_ROOT + 1;
	localparam int ST_MUL  = ST_DIFF + 1;
	localparam int ST_DIVO = ST_MUL + DIV_STAGES + 1;
	localparam int ST_OUT  = ST_DIVO + 1;
	localparam int ST_HEAD = CORDIC_STAGES + 2;

	localparam logic [30:0] FOLLOW_RESET = 31'd65536;
	localparam logic [31:0] ANG_QUARTER  = 32'h4000_0000;
	localparam logic [31:0] ANG_3QUARTER = 32'hC000_0000;
	localparam logic [31:0] ANG_ROUND    = 32'h0000_8000;

	localparam logic [31:0] ATAN_TURN32 [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
	} target_t;

	typedef struct packed {
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
		logic signed [15:0] heading;
		logic        [31:0] range_3d;
		logic               send_goal;
		logic               degenerate;
	} goal_t;

	typedef struct packed {
		logic sx;
		logic sy;
		logic degen;
	} flags_t;

	typedef struct packed {
		logic [31:0] ax;
		logic [31:0] ay;
	} mag_t;

endpackage
`default_nettype wire

@@ rtl/fgp_isqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module fgp_isqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] value,
	output logic      [31:0] root
);

	localparam int N = fgp_pkg::ISQRT_STAGES;

	logic [63:0] rem_q  [1:N];
	logic [31:0] root_q [1:N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int B = N - 1 - k;
		logic [63:0] rem_in;
		logic [31:0] root_in;
		logic [65:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_in  = value;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_q[k];
			assign root_in = root_q[k];
		end

		assign trial = ({34'd0, root_in} << (B + 1)) + (66'd1 << (2 * B));
		assign ge    = {2'b00, rem_in} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= ge ? rem_in - trial[63:0] : rem_in;
				root_q[k+1] <= ge ? (root_in | (32'd1 << B)) : root_in;
			end
		end
	end

	assign root = root_q[N];

endmodule
`default_nettype wire

@@ rtl/fgp_div.sv @@
// Pipelined restoring divider, 64 by 32 bits, with quotient overflow flag.
`default_nettype none
module fgp_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] num,
	input  wire logic [31:0] den,
	output logic      [31:0] quo,
	output logic             ovf
);

	localparam int N = fgp_pkg::DIV_STAGES;

	logic [31:0] rem_q [0:N];
	logic [31:0] lo_q  [0:N];
	logic [31:0] den_q [0:N];
	logic [31:0] quo_q [0:N];
	logic        ovf_q [0:N];

	// Entry: a quotient of 2^32 or more shows as overflow.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= num[63:32];
			lo_q[0]  <= num[31:0];
			den_q[0] <= den;
			quo_q[0] <= '0;
			ovf_q[0] <= num[63:32] >= den;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int B = N - 1 - k;
		logic [32:0] sh;
		logic        ge;

		assign sh = {rem_q[k], lo_q[k][B]};
		assign ge = sh >= {1'b0, den_q[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= ge ? 32'(sh - {1'b0, den_q[k]}) : sh[31:0];
				lo_q[k+1]  <= lo_q[k];
				den_q[k+1] <= den_q[k];
				quo_q[k+1] <= ge ? (quo_q[k] | (32'd1 << B)) : quo_q[k];
				ovf_q[k+1] <= ovf_q[k];
			end
		end
	end

	assign quo = quo_q[N];
	assign ovf = ovf_q[N];

endmodule
`default_nettype wire

@@ rtl/follow_goal_point.sv @@
// Top level of the follow goal point pipeline.
// Each target word (x, y, z, signed Q16.16 m) yields one goal word: a goal on
// the line of sight one follow distance short of the target, the heading as
// a binary angle, the 3D range, a send flag (range over follow distance) and
// a degenerate flag for a zero planar offset. One word enters every clock
// unless the output stalls. The 32-stage square root and the 32-stage divider
// run in series (a CORDIC runs alongside). The whole pipe holds when the
// output word is not taken. The follow distance port is always ready; it must
// be written only while no word is in flight; the block does not enforce it.
`default_nettype none
module follow_goal_point (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              target_valid,
	output logic                   target_ready,
	input  wire fgp_pkg::target_t  target,
	output logic                   goal_valid,
	input  wire logic              goal_ready,
	output fgp_pkg::goal_t         goal,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [30:0]       cfg_data
);

	localparam int L  = fgp_pkg::ST_OUT;
	localparam int CS = fgp_pkg::CORDIC_STAGES;

	logic        en;
	logic [L:1]  v_q;
	logic [30:0] fd_q;

	// advance everything when the output register is free or being taken
	assign en           = ~v_q[L] | goal_ready;
	assign target_ready = en;
	assign goal_valid   = v_q[L];
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= '0;
			fd_q <= fgp_pkg::FOLLOW_RESET;
		end else begin
			if (en) begin
				v_q <= {v_q[L-1:1], target_valid};
			end
			if (cfg_valid) begin
				fd_q <= cfg_data;
			end
		end
	end

	// stage 1: magnitudes, signs, degenerate check
	logic [31:0] az_s1;
	logic [63:0] sqx_s2, sqy_s2, sqz_s2;
	logic [63:0] planar_s3, full_s3;
	fgp_pkg::flags_t flag_q [1:fgp_pkg::ST_DIVO];
	fgp_pkg::mag_t   mag_q  [1:fgp_pkg::ST_DIFF];

	always_ff @(posedge clk) begin
		if (en) begin
			flag_q[1].sx    <= target.target_x[31];
			flag_q[1].sy    <= target.target_y[31];
			flag_q[1].degen <= (target.target_x == '0) && (target.target_y == '0);
			mag_q[1].ax <= target.target_x[31] ? 32'(-target.target_x) : target.target_x;
			mag_q[1].ay <= target.target_y[31] ? 32'(-target.target_y) : target.target_y;
			az_s1       <= target.target_z[31] ? 32'(-target.target_z) : target.target_z;
			for (int k = 2; k <= fgp_pkg::ST_DIVO; k++) flag_q[k] <= flag_q[k-1];
			for (int k = 2; k <= fgp_pkg::ST_DIFF; k++) mag_q[k] <= mag_q[k-1];
			// stage 2: squares
			sqx_s2 <= mag_q[1].ax * mag_q[1].ax;
			sqy_s2 <= mag_q[1].ay * mag_q[1].ay;
			sqz_s2 <= az_s1 * az_s1;
			// stage 3: planar and full sums of squares
			planar_s3 <= sqx_s2 + sqy_s2;
			full_s3   <= sqx_s2 + sqy_s2 + sqz_s2;
		end
	end

	logic [31:0] r2_root, r3_root;

	fgp_isqrt u_sqrt_planar (.clk(clk), .en(en), .value(planar_s3), .root(r2_root));
	fgp_isqrt u_sqrt_full   (.clk(clk), .en(en), .value(full_s3),   .root(r3_root));

	// stage 36: stand-off difference and send flag
	logic [32:0] diff;
	logic [31:0] dabs_s36, r2_s36, r2_s37;
	logic [63:0] px_s37, py_s37;
	logic [31:0] r3_q    [fgp_pkg::ST_DIFF:fgp_pkg::ST_DIVO];
	logic        send_q  [fgp_pkg::ST_DIFF:fgp_pkg::ST_DIVO];
	logic        sdiff_q [fgp_pkg::ST_DIFF:fgp_pkg::ST_DIVO];

	assign diff = {1'b0, r2_root} - {2'b00, fd_q};

	always_ff @(posedge clk) begin
		if (en) begin
			dabs_s36 <= diff[32] ? 32'(-diff) : diff[31:0];
			r2_s36   <= r2_root;
			r3_q[fgp_pkg::ST_DIFF]    <= r3_root;
			send_q[fgp_pkg::ST_DIFF]  <= r3_root > {1'b0, fd_q};
			sdiff_q[fgp_pkg::ST_DIFF] <= diff[32];
			for (int k = fgp_pkg::ST_DIFF + 1; k <= fgp_pkg::ST_DIVO; k++) begin
				r3_q[k]    <= r3_q[k-1];
				send_q[k]  <= send_q[k-1];
				sdiff_q[k] <= sdiff_q[k-1];
			end
			// stage 37: magnitude products
			px_s37 <= mag_q[fgp_pkg::ST_DIFF].ax * dabs_s36;
			py_s37 <= mag_q[fgp_pkg::ST_DIFF].ay * dabs_s36;
			r2_s37 <= r2_s36;
		end
	end

	logic [31:0] qx, qy;
	logic        ovx, ovy;

	fgp_div u_div_x (.clk(clk), .en(en), .num(px_s37), .den(r2_s37), .quo(qx), .ovf(ovx));
	fgp_div u_div_y (.clk(clk), .en(en), .num(py_s37), .den(r2_s37), .quo(qy), .ovf(ovy));

	// CORDIC heading, starts at the input and runs beside the range path
	logic signed [35:0] cx_q [1:CS+1];
	logic signed [35:0] cy_q [1:CS+1];
	logic        [31:0] ca_q [1:CS+1];
	logic        [15:0] hd_q [fgp_pkg::ST_HEAD:fgp_pkg::ST_DIVO];
	logic signed [35:0] tx, ty;
	logic        [31:0] hround;

	assign tx     = 36'(target.target_x);
	assign ty     = 36'(target.target_y);
	assign hround = ca_q[CS+1] + fgp_pkg::ANG_ROUND;

	always_ff @(posedge clk) begin
		if (en) begin
			// rotate into the right half plane
			if (tx[35] && !ty[35]) begin
				cx_q[1] <= ty;
				cy_q[1] <= -tx;
				ca_q[1] <= fgp_pkg::ANG_QUARTER;
			end else if (tx[35]) begin
				cx_q[1] <= -ty;
				cy_q[1] <= tx;
				ca_q[1] <= fgp_pkg::ANG_3QUARTER;
			end else begin
				cx_q[1] <= tx;
				cy_q[1] <= ty;
				ca_q[1] <= '0;
			end
			hd_q[fgp_pkg::ST_HEAD] <= hround[31:16];
			for (int k = fgp_pkg::ST_HEAD + 1; k <= fgp_pkg::ST_DIVO; k++) hd_q[k] <= hd_q[k-1];
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_q[i+1][35]) begin
					cx_q[i+2] <= cx_q[i+1] + (cy_q[i+1] >>> i);
					cy_q[i+2] <= cy_q[i+1] - (cx_q[i+1] >>> i);
					ca_q[i+2] <= ca_q[i+1] + fgp_pkg::ATAN_TURN32[i];
				end else begin
					cx_q[i+2] <= cx_q[i+1] - (cy_q[i+1] >>> i);
					cy_q[i+2] <= cy_q[i+1] + (cx_q[i+1] >>> i);
					ca_q[i+2] <= ca_q[i+1] - fgp_pkg::ATAN_TURN32[i];
				end
			end
		end
	end

	// final stage: apply sign, saturate, zero goal and heading on a degenerate word
	function automatic logic [31:0] sat_goal(input logic neg, input logic ov,
			input logic [31:0] q);
		logic [31:0] r;
		if (neg) begin
			r = (ov || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
		end else begin
			r = (ov || q[31]) ? 32'h7FFF_FFFF : q;
		end
		return r;
	endfunction

	fgp_pkg::flags_t fl;
	assign fl = flag_q[fgp_pkg::ST_DIVO];

	always_ff @(posedge clk) begin
		if (en) begin
			goal.goal_x     <= fl.degen ? '0 :
				sat_goal(fl.sx ^ sdiff_q[fgp_pkg::ST_DIVO], ovx, qx);
			goal.goal_y     <= fl.degen ? '0 :
				sat_goal(fl.sy ^ sdiff_q[fgp_pkg::ST_DIVO], ovy, qy);
			goal.heading    <= fl.degen ? '0 : hd_q[fgp_pkg::ST_DIVO];
			goal.range_3d   <= r3_q[fgp_pkg::ST_DIVO];
			goal.send_goal  <= send_q[fgp_pkg::ST_DIVO];
			goal.degenerate <= fl.degen;
		end
	end

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		goal_valid && goal.degenerate |->
			goal.goal_x == '0 && goal.goal_y == '0 && goal.heading == '0)
		else $error("degenerate word with nonzero goal or heading");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> v_q == $past(v_q))
		else $error("valid chain moved during a stall");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		target_valid && target_ready |=> v_q[1])
		else $error("accepted word lost at entry");
`endif

endmodule
`default_nettype wire

@@ tb/tb_follow_goal_point.sv @@
// Testbench for the follow goal point pipeline: directed and random targets.
module tb_follow_goal_point;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 71;
	localparam int CYCLE_CAP = 100000;

	logic             clk;
	logic             arst_n;
	logic             target_valid;
	logic             target_ready;
	fgp_pkg::target_t target;
	logic             goal_valid;
	logic             goal_ready;
	fgp_pkg::goal_t   goal;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [30:0]      cfg_data;

	// Predictor's own copy of the stand-off register.
	logic [30:0]    standoff;
	fgp_pkg::goal_t pending_goals [$];
	int             fail_count;
	int             cycle_count;
	bit             rx_stall_on;

	follow_goal_point dut (
		.clk(clk),
		.arst_n(arst_n),
		.target_valid(target_valid),
		.target_ready(target_ready),
		.target(target),
		.goal_valid(goal_valid),
		.goal_ready(goal_ready),
		.goal(goal),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Integer square root, rounded down.
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// CORDIC vectoring on the planar offset; >>> on longint rounds toward minus infinity.
	function automatic logic [15:0] bearing_of(longint x, longint y);
		logic [31:0] acc;
		longint      t;
		longint      dx;
		longint      dy;
		logic [31:0] rounded;
		acc = '0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				acc = fgp_pkg::ANG_QUARTER;
			end else begin
				x = -y;
				y = t;
				acc = fgp_pkg::ANG_3QUARTER;
			end
		end
		for (int i = 0; i < fgp_pkg::CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				acc += fgp_pkg::ATAN_TURN32[i];
			end else begin
				x -= dx;
				y += dy;
				acc -= fgp_pkg::ATAN_TURN32[i];
			end
		end
		rounded = acc + fgp_pkg::ANG_ROUND;
		return rounded[31:16];
	endfunction

	function automatic fgp_pkg::goal_t predict_goal(fgp_pkg::target_t tg);
		fgp_pkg::goal_t  g;
		longint          x;
		longint          y;
		longint          z;
		longint unsigned planar_sq;
		longint unsigned r2;
		longint unsigned r3;
		longint          diff;
		x = longint'(tg.target_x);
		y = longint'(tg.target_y);
		z = longint'(tg.target_z);
		planar_sq = longint'(x * x) + longint'(y * y);
		r2 = root_floor(planar_sq);
		r3 = root_floor(planar_sq + longint'(z * z));
		g = '0;
		g.degenerate = (r2 == 0);
		if (r2 != 0) begin
			diff = longint'(r2) - longint'({1'b0, standoff});
			// x*diff fits in 64 bits: |x| <= 2^31, |diff| < 2^32
			g.goal_x = clamp32((x * diff) / longint'(r2));
			g.goal_y = clamp32((y * diff) / longint'(r2));
			g.heading = bearing_of(x, y);
		end
		g.range_3d = r3[31:0];
		g.send_goal = (r3 > longint'({1'b0, standoff}));
		return g;
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic pause_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	// Send one target word, record its expected goal at acceptance.
	task automatic send_target(fgp_pkg::target_t tg, bit with_gaps);
		if (with_gaps) pause_cycles(gap_len());
		target = tg;
		target_valid = 1'b1;
		do @(posedge clk); while (!target_ready);
		pending_goals.push_back(predict_goal(tg));
		@(negedge clk);
		target_valid = 1'b0;
	endtask

	// Wait for every goal, then let the pipe drain before touching the register.
	task automatic drain_pipe();
		while (pending_goals.size() != 0) @(negedge clk);
		pause_cycles(LATENCY + 5);
	endtask

	task automatic write_standoff(logic [30:0] value);
		drain_pipe();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		standoff = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic fgp_pkg::target_t make_target(int x, int y, int z);
		fgp_pkg::target_t tg;
		tg.target_x = x;
		tg.target_y = y;
		tg.target_z = z;
		return tg;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, 600000) - 300000;
			2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
				: 32'h8000_0000 + $urandom_range(0, 255);
			default: return $urandom_range(0, 8) - 4;
		endcase
	endfunction

	// Extremes, zero planar range, target inside stand-off, axis headings.
	task automatic test_directed();
		send_target(make_target(0, 0, 0), 1'b0);
		send_target(make_target(0, 0, 32'h7FFF_FFFF), 1'b0);
		send_target(make_target(0, 0, 32'h8000_0000), 1'b0);
		send_target(make_target(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0);
		send_target(make_target(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0);
		send_target(make_target(32'h8000_0000, 0, 0), 1'b0);
		send_target(make_target(32'h8000_0000, -1, 0), 1'b0);
		send_target(make_target(32'h8000_0000, 1, 0), 1'b0);
		send_target(make_target(32'h7FFF_FFFF, 0, 0), 1'b0);
		send_target(make_target(0, 32'h7FFF_FFFF, 0), 1'b0);
		send_target(make_target(0, 32'h8000_0000, 0), 1'b0);
		send_target(make_target(1, 0, 0), 1'b0);
		send_target(make_target(-1, 0, 0), 1'b0);
		send_target(make_target(-1, -1, 1), 1'b0);
		send_target(make_target(0, 1, 0), 1'b0);
		send_target(make_target(32768, 32768, 0), 1'b1);
		send_target(make_target(65536, 0, 0), 1'b1);
		send_target(make_target(65537, 0, 0), 1'b1);
		send_target(make_target(-300000, 20000, -70000), 1'b1);
		send_target(make_target(-100, -100000, 5), 1'b1);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_target(make_target(rand_coord(), rand_coord(), rand_coord()), 1'b1);
	endtask

	// Back to back, hold until every expected goal is back, then a second burst.
	task automatic test_burst_and_hold();
		for (int i = 0; i < 40; i++)
			send_target(make_target(rand_coord(), rand_coord(), rand_coord()), 1'b0);
		while (pending_goals.size() != 0) @(negedge clk);
		for (int i = 0; i < 20; i++)
			send_target(make_target(rand_coord(), rand_coord(), rand_coord()), 1'b0);
	endtask

	// Receiver stalls at random on the falling edge while rx_stall_on is set.
	always @(negedge clk) begin
		if (!rx_stall_on) goal_ready <= 1'b1;
		else goal_ready <= ($urandom_range(0, 9) > 2);
	end

	// Check each accepted goal word against the oldest expectation.
	always @(posedge clk) begin
		fgp_pkg::goal_t want;
		if (arst_n && goal_valid && goal_ready) begin
			if (pending_goals.size() == 0) begin
				$display("%0t: unexpected goal word %h", $time, goal);
				fail_count++;
			end else begin
				want = pending_goals.pop_front();
				if (goal.goal_x !== want.goal_x) begin
					$display("%0t: goal_x expected %0d actual %0d", $time, want.goal_x,
						goal.goal_x);
					fail_count++;
				end
				if (goal.goal_y !== want.goal_y) begin
					$display("%0t: goal_y expected %0d actual %0d", $time, want.goal_y,
						goal.goal_y);
					fail_count++;
				end
				if (goal.heading !== want.heading) begin
					$display("%0t: heading expected %0d actual %0d", $time, want.heading,
						goal.heading);
					fail_count++;
				end
				if (goal.range_3d !== want.range_3d) begin
					$display("%0t: range_3d expected %0d actual %0d", $time, want.range_3d,
						goal.range_3d);
					fail_count++;
				end
				if (goal.send_goal !== want.send_goal) begin
					$display("%0t: send_goal expected %b actual %b", $time, want.send_goal,
						goal.send_goal);
					fail_count++;
				end
				if (goal.degenerate !== want.degenerate) begin
					$display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
						goal.degenerate);
					fail_count++;
				end
			end
		end
	end

	// Cycle watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("tb_follow_goal_point failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		target_valid = 1'b0;
		target = '0;
		goal_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		standoff = fgp_pkg::FOLLOW_RESET;
		fail_count = 0;
		cycle_count = 0;
		rx_stall_on = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset stand-off first, with the receiver always ready.
		test_directed();
		rx_stall_on = 1'b1;
		test_random(150);
		write_standoff('0);
		test_directed();
		test_random(120);
		write_standoff(31'h7FFF_FFFF);
		test_directed();
		test_random(120);
		write_standoff(31'h5555_5555);
		test_burst_and_hold();
		write_standoff(31'h2AAA_AAAA);
		test_random(120);
		write_standoff(31'($urandom_range(0, 400000)));
		test_random(100);
		rx_stall_on = 1'b0;
		test_random(30);

		// Drain what is in flight.
		while (pending_goals.size() != 0) @(negedge clk);
		pause_cycles(LATENCY + 10);
		if (fail_count == 0) begin
			$display("tb_follow_goal_point passed");
		end else begin
			$display("tb_follow_goal_point failed");
		end
		$finish;
	end

endmodule
